// ----- rtl/core/srs_pkg.sv -----
// Shared types and constants for the selective repeat sender core.
// Used by srs_ctrl, srs_dpath and selective_repeat_sender_core; no dependencies.
package srs_pkg;

  localparam int FRAME_W    = 16;
  localparam int WIN_W      = 3;
  localparam int MAX_WINDOW = 4;
  localparam int RES_DEPTH  = 4;
  localparam int RES_PTR_W  = 2;
  localparam int RES_CNT_W  = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [FRAME_W-1:0] TOTAL_FRAMES_RST = 16'd10;
  localparam logic [WIN_W-1:0]   WINDOW_SIZE_RST  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 1'b1;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_NAK     = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    KIND_NEW     = 2'd0,
    KIND_NAK     = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_END     = 2'd3
  } send_kind_t;

  typedef struct packed {
    cmd_code_t          command;
    logic [FRAME_W-1:0] frame_number;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] out_frame;
    send_kind_t         send_kind;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    send_kind_t         kind;
  } res_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SLIDE,
    ST_SCAN,
    ST_FILL,
    ST_END,
    ST_DRAIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic slide;
    logic scan;
    logic fill;
    logic end_chk;
    logic pop;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic      finished;
    cmd_code_t command;
    logic      slide_more;
    logic      scan_more;
    logic      fill_more;
    logic      has_results;
    logic      drain_last;
  } sts_t;

endpackage

// ----- rtl/core/selective_repeat_sender_core.sv -----
// Selective repeat ARQ sender, top level: sequencer plus datapath.
// Depends on srs_pkg, srs_ctrl and srs_dpath.
//
// Usage:
//   in_valid/in_ready carry one event item (start, ack, nak, timeout and the
//   frame number an ack or nak names). out_valid/out_ready carry the frames
//   to transmit, each tagged new, nak resend, timeout resend or end marker;
//   last_of_run flags the final item an event produces. An event that
//   produces nothing gives no output item at all.
//   cfg_we/cfg_index/cfg_data write total_frames (index 0) and window_size
//   (index 1), one register per write; write them only while the block is idle.
// Sequence:
//   One event at a time: accept, execute, one slide or scan step per slid base or
//   scanned slot plus a final one (ack, timeout), one fill step per new frame plus
//   a final one, an end check, then one output per buffered result (at most 4),
//   each taken while out_ready is high; in_ready stays low until the event is done.
// Reset:
//   Synchronous rst clears the window, marks and finished flag and loads
//   total_frames = 10, window_size = 4. A stalled receiver holds the current
//   result and blocks new events; after the end marker events are dropped.
module selective_repeat_sender_core #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  srs_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output srs_pkg::out_item_t             out_item
);

  srs_pkg::ctl_t ctl;
  srs_pkg::sts_t sts;

  // sequencer: one state per step of the event
  srs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  // window state, mark ring and result buffer
  srs_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .ctl       (ctl),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule

// ----- rtl/core/srs_ctrl.sv -----
// Sequencer for the selective repeat sender: walks each event through its steps.
// Depends on srs_pkg (state, command and status types).
module srs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          out_ready,
  input  srs_pkg::sts_t sts,
  output logic          in_ready,
  output logic          out_valid,
  output srs_pkg::ctl_t ctl
);

  srs_pkg::state_t state;
  srs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      srs_pkg::ST_IDLE: begin
        // after the end marker every item is swallowed
        if (in_valid && !sts.finished) state_next = srs_pkg::ST_EXEC;
      end
      srs_pkg::ST_EXEC: begin
        case (sts.command)
          srs_pkg::CMD_ACK:     state_next = srs_pkg::ST_SLIDE;
          srs_pkg::CMD_TIMEOUT: state_next = srs_pkg::ST_SCAN;
          default:              state_next = srs_pkg::ST_FILL;
        endcase
      end
      srs_pkg::ST_SLIDE: begin
        if (!sts.slide_more) state_next = srs_pkg::ST_FILL;
      end
      srs_pkg::ST_SCAN: begin
        if (!sts.scan_more) state_next = srs_pkg::ST_FILL;
      end
      srs_pkg::ST_FILL: begin
        if (!sts.fill_more) state_next = srs_pkg::ST_END;
      end
      srs_pkg::ST_END: begin
        state_next = sts.has_results ? srs_pkg::ST_DRAIN : srs_pkg::ST_IDLE;
      end
      srs_pkg::ST_DRAIN: begin
        if (out_ready && sts.drain_last) state_next = srs_pkg::ST_IDLE;
      end
      default: state_next = srs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == srs_pkg::ST_IDLE);
    out_valid   = (state == srs_pkg::ST_DRAIN);
    ctl.load    = (state == srs_pkg::ST_IDLE) && in_valid;
    ctl.exec    = (state == srs_pkg::ST_EXEC);
    ctl.slide   = (state == srs_pkg::ST_SLIDE);
    ctl.scan    = (state == srs_pkg::ST_SCAN);
    ctl.fill    = (state == srs_pkg::ST_FILL);
    ctl.end_chk = (state == srs_pkg::ST_END);
    ctl.pop     = (state == srs_pkg::ST_DRAIN) && out_ready;
  end

endmodule

// ----- rtl/core/srs_dpath.sv -----
// Datapath of the selective repeat sender: window pointers, slot marks,
// configuration registers and the per-event result buffer. Depends on srs_pkg.
module srs_dpath #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [srs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  srs_pkg::in_item_t                 in_item,
  input  srs_pkg::ctl_t                     ctl,
  output srs_pkg::sts_t                     sts,
  output srs_pkg::out_item_t                out_item
);

  localparam int SLOT_W  = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
  localparam int WIN_CAP = (SLOT_COUNT < srs_pkg::MAX_WINDOW) ? SLOT_COUNT
                                                               : srs_pkg::MAX_WINDOW;
  localparam logic [SLOT_W-1:0]   SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [SLOT_W:0]     SLOT_NUM  = (SLOT_W + 1)'(SLOT_COUNT);
  localparam logic [srs_pkg::WIN_W-1:0] WIN_MAX = srs_pkg::WIN_W'(WIN_CAP);

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
  endfunction

  logic [srs_pkg::FRAME_W-1:0] total_frames;
  logic [srs_pkg::WIN_W-1:0]   window_size;
  logic [srs_pkg::FRAME_W-1:0] window_base;
  logic [srs_pkg::FRAME_W-1:0] next_to_send;
  logic [SLOT_W-1:0]           base_slot;
  logic [SLOT_W-1:0]           next_slot;
  logic [SLOT_COUNT-1:0]       marks;
  logic                        finished;

  srs_pkg::cmd_code_t          cmd_q;
  logic [srs_pkg::FRAME_W-1:0] frame_q;
  logic [srs_pkg::FRAME_W-1:0] scan_frame;
  logic [SLOT_W-1:0]           scan_slot;

  srs_pkg::res_entry_t         res_buf [srs_pkg::RES_DEPTH];
  logic [srs_pkg::RES_CNT_W-1:0] res_count;
  logic [srs_pkg::RES_PTR_W-1:0] rd_ptr;

  logic [srs_pkg::WIN_W-1:0]   eff_win;
  logic                        in_window;
  logic [srs_pkg::FRAME_W-1:0] frame_off;
  logic [SLOT_W:0]             slot_sum;
  logic [SLOT_W-1:0]           frame_slot;
  logic                        nak_hit;
  logic                        slide_more;
  logic                        scan_more;
  logic                        fill_more;
  logic                        end_due;
  logic                        push_en;
  srs_pkg::res_entry_t         push_entry;

  // clamp the window to 1..min(4, slot count)
  always_comb begin
    if (window_size == '0) begin
      eff_win = srs_pkg::WIN_W'(1);
    end else if (window_size > WIN_MAX) begin
      eff_win = WIN_MAX;
    end else begin
      eff_win = window_size;
    end
  end

  // slot of the named frame, from the base slot plus a short offset
  always_comb begin
    in_window  = (frame_q >= window_base) && (frame_q < next_to_send);
    frame_off  = frame_q - window_base;
    slot_sum   = {1'b0, base_slot} + {1'b0, frame_off[SLOT_W-1:0]};
    frame_slot = (slot_sum >= SLOT_NUM) ? SLOT_W'(slot_sum - SLOT_NUM)
                                        : slot_sum[SLOT_W-1:0];
    nak_hit    = in_window && marks[frame_slot];
    slide_more = (window_base < next_to_send) && !marks[base_slot];
    scan_more  = (scan_frame < next_to_send);
    fill_more  = ({1'b0, next_to_send} <
                  ({1'b0, window_base} + (srs_pkg::FRAME_W + 1)'(eff_win)))
                 && (next_to_send < total_frames);
    end_due    = (window_base >= total_frames) && (window_base == next_to_send);
  end

  always_comb begin
    push_en          = 1'b0;
    push_entry.frame = next_to_send;
    push_entry.kind  = srs_pkg::KIND_NEW;
    if (ctl.exec && (cmd_q == srs_pkg::CMD_NAK) && nak_hit) begin
      push_en          = 1'b1;
      push_entry.frame = frame_q;
      push_entry.kind  = srs_pkg::KIND_NAK;
    end else if (ctl.scan && scan_more && marks[scan_slot]) begin
      push_en          = 1'b1;
      push_entry.frame = scan_frame;
      push_entry.kind  = srs_pkg::KIND_TIMEOUT;
    end else if (ctl.fill && fill_more) begin
      push_en          = 1'b1;
    end else if (ctl.end_chk && end_due) begin
      push_en          = 1'b1;
      push_entry.frame = '0;
      push_entry.kind  = srs_pkg::KIND_END;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_frames <= srs_pkg::TOTAL_FRAMES_RST;
      window_size  <= srs_pkg::WINDOW_SIZE_RST;
      window_base  <= '0;
      next_to_send <= '0;
      base_slot    <= '0;
      next_slot    <= '0;
      marks        <= '0;
      finished     <= 1'b0;
      res_count    <= '0;
      rd_ptr       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          srs_pkg::REG_TOTAL_FRAMES: total_frames <= cfg_data;
          srs_pkg::REG_WINDOW_SIZE:  window_size  <= cfg_data[srs_pkg::WIN_W-1:0];
          default: ;
        endcase
      end
      if (ctl.load) begin
        res_count <= '0;
        rd_ptr    <= '0;
      end
      if (ctl.exec && (cmd_q == srs_pkg::CMD_ACK) && in_window) begin
        marks[frame_slot] <= 1'b0;
      end
      if (ctl.slide && slide_more) begin
        window_base <= window_base + srs_pkg::FRAME_W'(1);
        base_slot   <= slot_inc(base_slot);
      end
      if (ctl.fill && fill_more) begin
        marks[next_slot] <= 1'b1;
        next_to_send     <= next_to_send + srs_pkg::FRAME_W'(1);
        next_slot        <= slot_inc(next_slot);
      end
      if (ctl.end_chk && end_due) begin
        finished <= 1'b1;
      end
      if (push_en) begin
        res_count <= res_count + srs_pkg::RES_CNT_W'(1);
      end
      if (ctl.pop) begin
        rd_ptr <= rd_ptr + srs_pkg::RES_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= in_item.command;
      frame_q <= in_item.frame_number;
    end
    if (ctl.exec && (cmd_q == srs_pkg::CMD_TIMEOUT)) begin
      scan_frame <= window_base;
      scan_slot  <= base_slot;
    end else if (ctl.scan && scan_more) begin
      scan_frame <= scan_frame + srs_pkg::FRAME_W'(1);
      scan_slot  <= slot_inc(scan_slot);
    end
    if (push_en) begin
      res_buf[res_count[srs_pkg::RES_PTR_W-1:0]] <= push_entry;
    end
  end

  always_comb begin
    sts.finished    = finished;
    sts.command     = cmd_q;
    sts.slide_more  = slide_more;
    sts.scan_more   = scan_more;
    sts.fill_more   = fill_more;
    sts.has_results = (res_count != '0) || end_due;
    sts.drain_last  = ({1'b0, rd_ptr} == (res_count - srs_pkg::RES_CNT_W'(1)));
    out_item.out_frame   = res_buf[rd_ptr].frame;
    out_item.send_kind   = res_buf[rd_ptr].kind;
    out_item.last_of_run = sts.drain_last;
  end

endmodule

// ----- tb/srs_send_checker.sv -----
// Checker for the selective repeat sender core: watches the config port and both
// item channels, predicts the frames to send and compares them in order.
// Depends on srs_pkg.
module srs_send_checker
  import srs_pkg::*;
#(
  parameter int SLOT_COUNT = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_item,
  input  logic                  drain_done,
  output int                    fail_count,
  output int                    pending,
  output int unsigned           base_hint,
  output int unsigned           next_hint
);

  localparam int PRINT_CAP = 40;

  out_item_t expected_sends[$];

  // predicted sender state and register copies
  int unsigned total_cfg;
  int unsigned win_cfg;
  int unsigned base_q;
  int unsigned next_q;
  bit [SLOT_COUNT-1:0] marks_q;
  bit done_q;
  bit closed;

  out_item_t run_buf[MAX_WINDOW];
  int run_len;
  int errors;

  initial begin
    errors = 0;
    closed = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (errors < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  function automatic void add_send(input int unsigned frame, input send_kind_t kind);
    if (run_len < MAX_WINDOW) begin
      run_buf[run_len].out_frame = frame[FRAME_W-1:0];
      run_buf[run_len].send_kind = kind;
      run_buf[run_len].last_of_run = 1'b0;
      run_len++;
    end
  endfunction

  function automatic int unsigned slot_of(input int unsigned frame);
    return frame % SLOT_COUNT;
  endfunction

  task automatic predict_sends(input in_item_t it);
    int unsigned w;
    int unsigned f;
    int unsigned i;
    w = win_cfg;
    if (w < 1) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    if (w > SLOT_COUNT) w = SLOT_COUNT;
    f = it.frame_number;
    run_len = 0;
    if (done_q) return;
    case (it.command)
      CMD_ACK: begin
        if (f >= base_q && f < next_q) begin
          marks_q[slot_of(f)] = 1'b0;
          while (base_q < next_q && !marks_q[slot_of(base_q)]) base_q++;
        end
      end
      CMD_NAK: begin
        if (f >= base_q && f < next_q && marks_q[slot_of(f)]) add_send(f, KIND_NAK);
      end
      CMD_TIMEOUT: begin
        for (i = base_q; i < next_q; i++)
          if (marks_q[slot_of(i)]) add_send(i, KIND_TIMEOUT);
      end
      default: ;
    endcase
    // refill the window
    while (next_q < base_q + w && next_q < total_cfg) begin
      marks_q[slot_of(next_q)] = 1'b1;
      add_send(next_q, KIND_NEW);
      next_q++;
    end
    if (base_q >= total_cfg && base_q == next_q) begin
      add_send(0, KIND_END);
      done_q = 1'b1;
    end
    if (run_len > 0) run_buf[run_len-1].last_of_run = 1'b1;
    for (i = 0; i < run_len; i++) expected_sends.push_back(run_buf[i]);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      total_cfg = TOTAL_FRAMES_RST;
      win_cfg = WINDOW_SIZE_RST;
      base_q = 0;
      next_q = 0;
      marks_q = '0;
      done_q = 1'b0;
      expected_sends.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TOTAL_FRAMES) total_cfg = cfg_data;
        else if (cfg_index == REG_WINDOW_SIZE) win_cfg = cfg_data[WIN_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (expected_sends.size() == 0) begin
          report_mismatch($sformatf("unexpected item frame %0d kind %0d",
                                    out_item.out_frame, out_item.send_kind));
        end else begin
          want = expected_sends.pop_front();
          if (out_item.out_frame !== want.out_frame)
            report_mismatch($sformatf("out_frame %0d, want %0d",
                                      out_item.out_frame, want.out_frame));
          if (out_item.send_kind !== want.send_kind)
            report_mismatch($sformatf("send_kind %0d, want %0d (frame %0d)",
                                      out_item.send_kind, want.send_kind, want.out_frame));
          if (out_item.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %0b, want %0b (frame %0d)",
                                      out_item.last_of_run, want.last_of_run,
                                      want.out_frame));
        end
      end
      if (in_valid && in_ready) predict_sends(in_item);
      if (drain_done && !closed) begin
        closed = 1'b1;
        if (expected_sends.size() != 0)
          report_mismatch($sformatf("%0d items never sent", expected_sends.size()));
      end
    end
    fail_count <= errors;
    pending <= expected_sends.size();
    base_hint <= base_q;
    next_hint <= next_q;
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the selective repeat sender testbench: clock, reset, event stimulus,
// config phases and the verdict. Depends on srs_pkg, srs_send_checker and the core.
module tb_top;
  import srs_pkg::*;

  localparam int SLOTS = 8;
  // cycles with no handshake and no config write before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // quiet cycles after the last result: covers an event that sends nothing
  localparam int SETTLE = 24;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  drain_done = 1'b0;

  int          fail_count;
  int          pending;
  int unsigned base_hint;
  int unsigned next_hint;

  // calm = 1 turns off all idling on both sides
  bit calm = 1'b0;
  int idle_cycles = 0;

  always #4 clk = ~clk;

  selective_repeat_sender_core #(.SLOT_COUNT(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  srs_send_checker #(.SLOT_COUNT(SLOTS)) checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .drain_done (drain_done),
    .fail_count (fail_count),
    .pending    (pending),
    .base_hint  (base_hint),
    .next_hint  (next_hint)
  );

  // Stall the receiver at random about 21 percent of the time, never while calm.
  always @(posedge clk) begin
    if (calm) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) >= 21);
  end

  // Watchdog: end the run once nothing has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Offer one event item and hold it until it is accepted; sometimes idle first.
  task automatic send_event(input cmd_code_t cmd, input logic [FRAME_W-1:0] fn);
    if (!calm && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item.command <= cmd;
    in_item.frame_number <= fn;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold off until every predicted item has come out.
  task automatic wait_drained(input int settle);
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < 1500);
    repeat (settle) @(posedge clk);
  endtask

  // Write both registers on back-to-back cycles; call only while drained.
  task automatic write_regs(input logic [CFG_DATA_W-1:0] total_val,
                            input logic [CFG_DATA_W-1:0] win_val);
    cfg_we <= 1'b1;
    cfg_index <= REG_TOTAL_FRAMES;
    cfg_data <= total_val;
    @(posedge clk);
    cfg_index <= REG_WINDOW_SIZE;
    cfg_data <= win_val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Frame inside the predicted window, the base most of the time.
  function automatic logic [FRAME_W-1:0] window_frame();
    int unsigned span;
    if (next_hint <= base_hint) return base_hint[FRAME_W-1:0];
    span = next_hint - base_hint;
    if ($urandom_range(0, 99) < 60) return base_hint[FRAME_W-1:0];
    return FRAME_W'(base_hint + $urandom_range(0, span - 1));
  endfunction

  // Mostly well-formed link events aimed at the live window, some noise.
  task automatic run_phase(input int count, input bit quiet);
    int r;
    logic [FRAME_W-1:0] fn;
    calm = quiet;
    for (int k = 0; k < count; k++) begin
      // now and then hold off until the sender has caught up
      if ($urandom_range(0, 24) == 0) wait_drained(0);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_event(CMD_ACK, window_frame());
      end else if (r < 60) begin
        send_event(CMD_NAK, window_frame());
      end else if (r < 72) begin
        send_event(CMD_TIMEOUT, FRAME_W'($urandom));
      end else if (r < 80) begin
        send_event(CMD_START, FRAME_W'($urandom));
      end else begin
        // broken events: any command, a frame near the window or anywhere
        if ($urandom_range(0, 1)) fn = FRAME_W'($urandom);
        else fn = FRAME_W'(base_hint + $urandom_range(0, 8) - 2);
        send_event(cmd_code_t'($urandom_range(0, 3)), fn);
      end
    end
    wait_drained(SETTLE);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset settings (10 frames, window 4).
    send_event(CMD_START, 16'hFFFF);    // fill 0..3, frame field ignored
    send_event(CMD_NAK, 16'd0);         // frame 0 can be resent too
    send_event(CMD_ACK, 16'd2);         // hole: no slide
    send_event(CMD_NAK, 16'd2);         // already acked: nothing
    send_event(CMD_NAK, 16'd3);
    send_event(CMD_NAK, 16'hFFFF);      // outside the window
    send_event(CMD_ACK, 16'hFFFF);      // outside the window
    send_event(CMD_ACK, 16'd0);         // slide to 1, refill
    send_event(CMD_ACK, 16'd1);         // slide over the acked hole
    send_event(CMD_TIMEOUT, 16'hAAAA);  // resend everything outstanding
    send_event(CMD_START, 16'h5555);
    send_event(CMD_NAK, 16'd0);         // below the base now
    wait_drained(SETTLE);

    // Window register zero acts as one; upper data bits are dropped.
    write_regs(16'hFFFF, 16'hFFF8);
    send_event(CMD_TIMEOUT, 16'd0);
    send_event(CMD_ACK, 16'd3);
    send_event(CMD_ACK, 16'd4);
    wait_drained(SETTLE);

    // Window seven clamps to four.
    write_regs(16'hFFFF, 16'd7);
    send_event(CMD_START, 16'd0);
    send_event(CMD_TIMEOUT, 16'hFFFF);
    wait_drained(SETTLE);

    // Random phases over several settings; one long stretch with no idling.
    write_regs(16'hFFFF, 16'd1);
    run_phase(35, 1'b0);
    write_regs(16'hFFFF, 16'd4);
    run_phase(40, 1'b1);
    write_regs(16'd300, 16'h0002);
    run_phase(35, 1'b0);
    write_regs(16'hFFFF, 16'hFFF3);
    run_phase(35, 1'b0);
    write_regs(16'hFFFF, CFG_DATA_W'($urandom_range(5, 6)));
    run_phase(35, 1'b0);
    write_regs(16'hFFFF, 16'h0000);
    run_phase(30, 1'b0);

    // Lower the frame count below what has been sent: only resends and acks,
    // then the end marker once the window empties, then nothing at all.
    write_regs(16'd1, 16'd4);
    run_phase(25, 1'b0);
    write_regs(16'd0, 16'd3);
    run_phase(15, 1'b0);

    calm = 1'b0;
    wait_drained(SETTLE);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
